>>> src/assert_macros.svh
// Assertion macros used by the search engine core.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// When pre holds, post must hold at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)

`endif

`endif

>>> src/owse_pkg.sv
// ----------------------------------------------------------------------------
// owse_pkg
// Types and codes shared by the 1-Wire search-ROM engine.
// ----------------------------------------------------------------------------
`default_nettype none

package owse_pkg;

    localparam int unsigned ROM_BITS     = 64;
    localparam int unsigned POS_W        = 7;
    localparam int unsigned FAMILY_LIMIT = 9;
    localparam int unsigned LFD_W        = 4;

    localparam logic [7:0] SEARCH_CMD_RESET = 8'd240;

    // Input opcodes
    localparam logic [2:0] OP_FIRST   = 3'd0;
    localparam logic [2:0] OP_NEXT    = 3'd1;
    localparam logic [2:0] OP_VERIFY  = 3'd2;
    localparam logic [2:0] OP_RST_OUT = 3'd3;
    localparam logic [2:0] OP_BITPAIR = 3'd4;
    localparam logic [2:0] OP_TARGET  = 3'd5;
    localparam logic [2:0] OP_SKIP    = 3'd6;

    // Result status codes
    localparam logic [2:0] ST_RESET   = 3'd0;
    localparam logic [2:0] ST_CMD     = 3'd1;
    localparam logic [2:0] ST_DIR     = 3'd2;
    localparam logic [2:0] ST_FOUND   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;
    localparam logic [2:0] ST_SETUP   = 3'd5;
    localparam logic [2:0] ST_IGNORED = 3'd6;

    typedef struct packed {
        logic [2:0] opcode;
        logic       id_bit;
        logic       complement_bit;
        logic       presence_absent;
        logic [7:0] family_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]          status;
        logic                direction;
        logic [7:0]          command_byte;
        logic [ROM_BITS-1:0] rom_id;
        logic                verify_match;
    } t_out_word;

endpackage

`default_nettype wire

>>> src/owse_core.sv
// ----------------------------------------------------------------------------
// owse_core
// Search state registers and the combinational step logic that turns one
// registered input word into one result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module owse_core
    import owse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_word  i_word,
    input  wire logic [7:0] i_search_cmd,
    output t_out_word      o_result
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RESET = 2'd1;
    localparam logic [1:0] PH_BITS  = 2'd2;

    localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(ROM_BITS);
    localparam logic [POS_W-1:0] POS_FAMILY = POS_W'(FAMILY_LIMIT);

    logic [ROM_BITS-1:0] r_rom,      n_rom;
    logic [POS_W-1:0]    r_ld,       n_ld;
    logic [LFD_W-1:0]    r_lfd,      n_lfd;
    logic                r_ldf,      n_ldf;
    logic [POS_W-1:0]    r_bit_pos,  n_bit_pos;
    logic [POS_W-1:0]    r_lzp,      n_lzp;
    logic [1:0]          r_phase,    n_phase;
    logic                r_verify,   n_verify;
    logic [ROM_BITS-1:0] r_bk_rom,   n_bk_rom;
    logic [POS_W-1:0]    r_bk_ld,    n_bk_ld;
    logic                r_bk_ldf,   n_bk_ldf;
    logic [LFD_W-1:0]    r_bk_lfd,   n_bk_lfd;

    always_comb begin
        t_out_word        res;
        logic             do_finish;
        logic             fin_found;
        logic             fin_dir;
        logic             ok;
        logic             dir;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] pos_m1;
        logic [5:0]       idx;

        n_rom     = r_rom;
        n_ld      = r_ld;
        n_lfd     = r_lfd;
        n_ldf     = r_ldf;
        n_bit_pos = r_bit_pos;
        n_lzp     = r_lzp;
        n_phase   = r_phase;
        n_verify  = r_verify;
        n_bk_rom  = r_bk_rom;
        n_bk_ld   = r_bk_ld;
        n_bk_ldf  = r_bk_ldf;
        n_bk_lfd  = r_bk_lfd;

        res        = '0;
        res.status = ST_IGNORED;
        do_finish  = 1'b0;
        fin_found  = 1'b0;
        fin_dir    = 1'b0;
        ok         = 1'b0;
        dir        = 1'b0;
        pos        = r_bit_pos;
        pos_m1     = POS_W'(r_bit_pos - POS_FIRST);
        idx        = pos_m1[5:0];

        unique case (i_word.opcode) inside
            OP_FIRST, OP_NEXT, OP_VERIFY: begin
                if (r_phase == PH_IDLE) begin
                    if (i_word.opcode == OP_FIRST) begin
                        n_ld     = '0;
                        n_lfd    = '0;
                        n_ldf    = 1'b0;
                        n_verify = 1'b0;
                    end else if (i_word.opcode == OP_NEXT) begin
                        n_verify = 1'b0;
                    end else begin
                        n_bk_rom = r_rom;
                        n_bk_ld  = r_ld;
                        n_bk_ldf = r_ldf;
                        n_bk_lfd = r_lfd;
                        n_ld     = POS_LAST;
                        n_ldf    = 1'b0;
                        n_verify = 1'b1;
                    end
                    n_bit_pos = POS_FIRST;
                    n_lzp     = '0;
                    if (n_ldf) begin
                        do_finish = 1'b1;
                    end else begin
                        n_phase    = PH_RESET;
                        res.status = ST_RESET;
                    end
                end
            end
            OP_RST_OUT: begin
                if (r_phase == PH_RESET) begin
                    if (i_word.presence_absent) begin
                        do_finish = 1'b1;
                    end else begin
                        n_phase          = PH_BITS;
                        res.status       = ST_CMD;
                        res.command_byte = i_search_cmd;
                    end
                end
            end
            OP_BITPAIR: begin
                if (r_phase == PH_BITS && pos >= POS_FIRST && pos <= POS_LAST) begin
                    if (i_word.id_bit && i_word.complement_bit) begin
                        do_finish = 1'b1;
                    end else begin
                        if (i_word.id_bit != i_word.complement_bit) begin
                            dir = i_word.id_bit;
                        end else begin
                            if (pos < r_ld) begin
                                dir = r_rom[idx];
                            end else begin
                                dir = (pos == r_ld);
                            end
                            if (!dir) begin
                                n_lzp = pos;
                                if (pos < POS_FAMILY) begin
                                    n_lfd = pos[LFD_W-1:0];
                                end
                            end
                        end
                        n_rom[idx] = dir;
                        n_bit_pos  = POS_W'(pos + POS_FIRST);
                        if (pos == POS_LAST) begin
                            do_finish = 1'b1;
                            fin_found = 1'b1;
                            fin_dir   = dir;
                        end else begin
                            res.status    = ST_DIR;
                            res.direction = dir;
                        end
                    end
                end
            end
            OP_TARGET: begin
                if (r_phase == PH_IDLE) begin
                    n_rom      = ROM_BITS'(i_word.family_byte);
                    n_ld       = POS_LAST;
                    n_lfd      = '0;
                    n_ldf      = 1'b0;
                    res.status = ST_SETUP;
                end
            end
            OP_SKIP: begin
                if (r_phase == PH_IDLE) begin
                    n_ld       = POS_W'(r_lfd);
                    n_lfd      = '0;
                    if (r_lfd == '0) begin
                        n_ldf = 1'b1;
                    end
                    res.status = ST_SETUP;
                end
            end
            default: begin
                res.status = ST_IGNORED;
            end
        endcase

        // Common end of a search: found, none, and the verify restore.
        if (do_finish) begin
            ok = fin_found;
            if (fin_found) begin
                n_ld = n_lzp;
                if (n_lzp == '0) begin
                    n_ldf = 1'b1;
                end
            end
            if (!ok || n_rom[7:0] == 8'd0) begin
                n_ld  = '0;
                n_lfd = '0;
                n_ldf = 1'b0;
                ok    = 1'b0;
            end
            res.rom_id = ok ? n_rom : '0;
            if (n_verify) begin
                res.verify_match = ok && (n_rom == n_bk_rom);
                n_rom    = n_bk_rom;
                n_ld     = n_bk_ld;
                n_ldf    = n_bk_ldf;
                n_lfd    = n_bk_lfd;
                n_verify = 1'b0;
            end
            n_phase       = PH_IDLE;
            res.status    = ok ? ST_FOUND : ST_NONE;
            res.direction = fin_dir;
        end

        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom     <= '0;
            r_ld      <= '0;
            r_lfd     <= '0;
            r_ldf     <= 1'b0;
            r_bit_pos <= POS_FIRST;
            r_lzp     <= '0;
            r_phase   <= PH_IDLE;
            r_verify  <= 1'b0;
        end else if (i_step) begin
            r_rom     <= n_rom;
            r_ld      <= n_ld;
            r_lfd     <= n_lfd;
            r_ldf     <= n_ldf;
            r_bit_pos <= n_bit_pos;
            r_lzp     <= n_lzp;
            r_phase   <= n_phase;
            r_verify  <= n_verify;
        end
    end

    // The backup copy is only read after a verify start has written it.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_bk_rom <= n_bk_rom;
            r_bk_ld  <= n_bk_ld;
            r_bk_ldf <= n_bk_ldf;
            r_bk_lfd <= n_bk_lfd;
        end
    end

    `ASSERT_IMPLY(a_pos_in_range, i_clk, i_rst_n, r_phase == PH_BITS,
        r_bit_pos >= POS_FIRST && r_bit_pos <= POS_LAST)
    `ASSERT_IMPLY(a_verify_busy, i_clk, i_rst_n, r_verify, r_phase != PH_IDLE)
    `ASSERT_IMPLY(a_cmd_only_on_cmd, i_clk, i_rst_n,
        i_step && o_result.command_byte != 8'd0, o_result.status == ST_CMD)
    `ASSERT_IMPLY(a_found_family, i_clk, i_rst_n, i_step && o_result.status == ST_FOUND,
        o_result.rom_id[7:0] != 8'd0)

endmodule

`default_nettype wire

>>> src/one_wire_rom_search_engine.sv
// ----------------------------------------------------------------------------
// one_wire_rom_search_engine
// Search-ROM sequencer for a 1-Wire master: one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
// The master sends words on the input channel (start first/next/verify, the
// reset presence outcome, each id/complement bit pair, target-family and
// family-skip setups). For every accepted word exactly one result word comes
// out on the output channel: issue reset, send command, write direction,
// found, none, setup done or ignored.
// An accepted word waits in the input register; its result word is written
// to the result register when the core steps, and the receiver takes it there.
// One word is accepted every cycle while the receiver does not stall; the state
// update for a word is a single step between the input and the result register.
// When the receiver stalls, the result register holds its word and the input
// register takes one more word; after that the input ready drops.
// The configuration channel writes the search command byte and is always
// ready; write it only while no word is in flight.
// Reset clears the search state, empties both registers and sets the search
// command to 0xF0.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_rom_search_engine
    import owse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_word   i_in_word,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out_word,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_word   r_in_word;
    logic       r_out_valid;
    t_out_word  r_out_word;
    logic [7:0] r_search_cmd;
    logic       advance;
    t_out_word  step_result;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    owse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_word       (r_in_word),
        .i_search_cmd (r_search_cmd),
        .o_result     (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_search_cmd <= SEARCH_CMD_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_search_cmd <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= step_result;
        end
    end

endmodule

`default_nettype wire

>>> verif/one_wire_rom_search_engine_tb.sv
// ----------------------------------------------------------------------------
// one_wire_rom_search_engine_tb
// Checks the search-ROM engine against a cycle-free model of its search state.
// A small bus model of 1-Wire devices answers each bit slot, so most searches
// run to completion, with random noise words and broken sequences mixed in.
// Both channels idle at random. The search command byte is rewritten between
// phases, only after every expected result word has come back.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_rom_search_engine_tb
    import owse_pkg::*;
;

    localparam logic [2:0]  OP_UNUSED   = 3'd7;
    localparam int unsigned N_ITEMS     = 1600;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_AWAIT_RESET,
        PH_BITS
    } t_phase;

    // Model of the engine plus the queue of result words still to come.
    class rom_search_scoreboard;
        t_out_word   expected_results[$];
        int unsigned fail_count;

        logic [63:0] rom_number;
        logic [6:0]  last_disc;
        logic [3:0]  last_family_disc;
        logic        last_device;
        logic [6:0]  bit_pos;
        logic [6:0]  last_zero_pos;
        t_phase      phase;
        logic        verify_mode;
        logic [63:0] backup_rom;
        logic [11:0] backup_disc;
        logic [7:0]  search_cmd;

        function new();
            fail_count       = 0;
            rom_number       = '0;
            last_disc        = '0;
            last_family_disc = '0;
            last_device      = 1'b0;
            bit_pos          = 7'd1;
            last_zero_pos    = '0;
            phase            = PH_IDLE;
            verify_mode      = 1'b0;
            backup_rom       = '0;
            backup_disc      = '0;
            search_cmd       = SEARCH_CMD_RESET;
        endfunction

        function void set_command(logic [7:0] cmd);
            search_cmd = cmd;
        endfunction

        function void clear_search();
            last_disc        = '0;
            last_family_disc = '0;
            last_device      = 1'b0;
        endfunction

        // Closes a search; a verify puts the saved search state back.
        function t_out_word end_search(logic found, logic dir);
            t_out_word r;
            logic      ok;
            ok = found;
            r  = '0;
            if (found) begin
                last_disc = last_zero_pos;
                if (last_disc == 0)
                    last_device = 1'b1;
            end
            if (!ok || rom_number[7:0] == 8'h00) begin
                clear_search();
                ok = 1'b0;
            end
            r.status    = ok ? ST_FOUND : ST_NONE;
            r.direction = dir;
            r.rom_id    = ok ? rom_number : '0;
            if (verify_mode) begin
                r.verify_match   = ok && (rom_number == backup_rom);
                rom_number       = backup_rom;
                last_disc        = backup_disc[6:0];
                last_device      = backup_disc[7];
                last_family_disc = backup_disc[11:8];
                verify_mode      = 1'b0;
            end
            phase = PH_IDLE;
            return r;
        endfunction

        function t_out_word note_word(t_in_word w);
            t_out_word   r;
            logic [6:0]  pos;
            logic        dir;
            logic [63:0] mask;
            r        = '0;
            r.status = ST_IGNORED;
            case (w.opcode) inside
                OP_FIRST, OP_NEXT, OP_VERIFY: begin
                    if (phase == PH_IDLE) begin
                        if (w.opcode == OP_FIRST) begin
                            clear_search();
                            verify_mode = 1'b0;
                        end else if (w.opcode == OP_NEXT) begin
                            verify_mode = 1'b0;
                        end else begin
                            backup_rom  = rom_number;
                            backup_disc = {last_family_disc, last_device, last_disc};
                            last_disc   = 7'(ROM_BITS);
                            last_device = 1'b0;
                            verify_mode = 1'b1;
                        end
                        bit_pos       = 7'd1;
                        last_zero_pos = '0;
                        if (last_device) begin
                            r = end_search(1'b0, 1'b0);
                        end else begin
                            phase    = PH_AWAIT_RESET;
                            r.status = ST_RESET;
                        end
                    end
                end
                OP_RST_OUT: begin
                    if (phase == PH_AWAIT_RESET) begin
                        if (w.presence_absent) begin
                            r = end_search(1'b0, 1'b0);
                        end else begin
                            phase          = PH_BITS;
                            r.status       = ST_CMD;
                            r.command_byte = search_cmd;
                        end
                    end
                end
                OP_BITPAIR: begin
                    if (phase == PH_BITS && bit_pos >= 1 && bit_pos <= ROM_BITS) begin
                        pos = bit_pos;
                        if (w.id_bit && w.complement_bit) begin
                            r = end_search(1'b0, 1'b0);
                        end else begin
                            mask = 64'd1 << (pos - 7'd1);
                            if (w.id_bit != w.complement_bit) begin
                                dir = w.id_bit;
                            end else begin
                                if (pos < last_disc)
                                    dir = |(rom_number & mask);
                                else
                                    dir = (pos == last_disc);
                                if (!dir) begin
                                    last_zero_pos = pos;
                                    if (pos < FAMILY_LIMIT)
                                        last_family_disc = pos[3:0];
                                end
                            end
                            rom_number = dir ? (rom_number | mask) : (rom_number & ~mask);
                            bit_pos    = pos + 7'd1;
                            if (bit_pos >= ROM_BITS + 1) begin
                                r = end_search(1'b1, dir);
                            end else begin
                                r.status    = ST_DIR;
                                r.direction = dir;
                            end
                        end
                    end
                end
                OP_TARGET: begin
                    if (phase == PH_IDLE) begin
                        rom_number       = {56'd0, w.family_byte};
                        last_disc        = 7'(ROM_BITS);
                        last_family_disc = '0;
                        last_device      = 1'b0;
                        r.status         = ST_SETUP;
                    end
                end
                OP_SKIP: begin
                    if (phase == PH_IDLE) begin
                        last_disc        = {3'd0, last_family_disc};
                        last_family_disc = '0;
                        if (last_disc == 0)
                            last_device = 1'b1;
                        r.status = ST_SETUP;
                    end
                end
                default: ;
            endcase
            expected_results.push_back(r);
            return r;
        endfunction

        function void check_word(t_out_word got);
            t_out_word exp_w;
            if (expected_results.size() == 0) begin
                $error("result word with no expectation: status %0d", got.status);
                fail_count++;
                return;
            end
            exp_w = expected_results.pop_front();
            if (got.status !== exp_w.status) begin
                $error("status: expected %0d, actual %0d", exp_w.status, got.status);
                fail_count++;
            end
            if (got.direction !== exp_w.direction) begin
                $error("direction: expected %0d, actual %0d", exp_w.direction, got.direction);
                fail_count++;
            end
            if (got.command_byte !== exp_w.command_byte) begin
                $error("command_byte: expected %02h, actual %02h",
                       exp_w.command_byte, got.command_byte);
                fail_count++;
            end
            if (got.rom_id !== exp_w.rom_id) begin
                $error("rom_id: expected %016h, actual %016h", exp_w.rom_id, got.rom_id);
                fail_count++;
            end
            if (got.verify_match !== exp_w.verify_match) begin
                $error("verify_match: expected %0d, actual %0d",
                       exp_w.verify_match, got.verify_match);
                fail_count++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_word  o_out_word;
    logic       o_cfg_ready;

    one_wire_rom_search_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    rom_search_scoreboard sb = new();

    // Devices on the simulated bus and which of them still follow the search.
    logic [63:0] bus_dev[$];
    bit          alive[$];
    int unsigned bit_idx    = 0;
    t_phase      drv_phase  = PH_IDLE;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("one_wire_rom_search_engine_tb failed");
            $finish;
        end
    end

    // Receiver: checks each accepted result word and stalls on its own pattern.
    int unsigned rx_cycle  = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned rx_mode   = 0;

    always @(posedge i_clk) begin
        rx_cycle++;
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_out_word);
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_cycle == 300 || rx_cycle == 3000 || $urandom_range(0, 2999) == 0) begin
            // Long hold-off so the input side fills up and stalls.
            hold_left = $urandom_range(60, 120);
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 99) < 85);
                default: i_out_ready <= (rx_cycle % 4 == 0);
            endcase
        end
    end

    function automatic t_in_word random_word();
        return t_in_word'($urandom);
    endfunction

    // Wired-AND read of the current slot over the devices still in the search.
    function automatic t_in_word bus_pair_word();
        t_in_word w;
        logic     all_one;
        logic     all_zero;
        w        = random_word();
        w.opcode = OP_BITPAIR;
        all_one  = 1'b1;
        all_zero = 1'b1;
        foreach (bus_dev[d]) begin
            if (alive[d]) begin
                if (bus_dev[d][bit_idx])
                    all_zero = 1'b0;
                else
                    all_one = 1'b0;
            end
        end
        w.id_bit         = all_one;
        w.complement_bit = all_zero;
        return w;
    endfunction

    task automatic new_bus(input bit zero_family);
        logic [63:0] base;
        logic [63:0] dev;
        int unsigned n;
        int unsigned lo;
        bus_dev.delete();
        alive.delete();
        n    = zero_family ? 3 : (($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6));
        lo   = zero_family ? 8 : 0;
        base = {$urandom, $urandom};
        if (zero_family)
            base[7:0] = 8'h00;
        repeat (n) begin
            dev = base;
            repeat ($urandom_range(1, 6))
                dev[$urandom_range(lo, 63)] = 1'($urandom_range(0, 1));
            bus_dev.push_back(dev);
            alive.push_back(1'b1);
        end
    endtask

    task automatic send_word(input t_in_word w, output t_out_word r);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        r = sb.note_word(w);
        items_sent++;
        case (r.status) inside
            ST_RESET: begin
                drv_phase = PH_AWAIT_RESET;
                bit_idx   = 0;
                foreach (alive[d])
                    alive[d] = 1'b1;
            end
            ST_CMD:             drv_phase = PH_BITS;
            ST_FOUND, ST_NONE:  drv_phase = PH_IDLE;
            default: ;
        endcase
        if (w.opcode == OP_BITPAIR && r.status == ST_DIR) begin
            foreach (bus_dev[d])
                if (bus_dev[d][bit_idx] != r.direction)
                    alive[d] = 1'b0;
            bit_idx++;
        end
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Runs the search in progress to its end, with an odd stray word.
    task automatic advance_search();
        t_in_word   w;
        t_out_word  r;
        logic [2:0] op;
        while (drv_phase != PH_IDLE) begin
            if ($urandom_range(0, 59) == 0) begin
                w  = random_word();
                op = 3'($urandom_range(0, 6));
                if (op >= OP_BITPAIR)
                    op = op + 3'd1;
                w.opcode = op;
            end else if (drv_phase == PH_AWAIT_RESET) begin
                w = random_word();
                w.opcode = OP_RST_OUT;
                w.presence_absent = (bus_dev.size() == 0) || ($urandom_range(0, 29) == 0);
            end else begin
                w = bus_pair_word();
                if ($urandom_range(0, 199) == 0)
                    {w.id_bit, w.complement_bit} = 2'($urandom_range(0, 3));
            end
            send_word(w, r);
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
    endtask

    task automatic write_command(input logic [7:0] cmd);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cmd;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_command(cmd);
    endtask

    initial begin
        t_in_word    w;
        t_out_word   r;
        int unsigned sel;
        int unsigned next_cfg_at;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: stray words while idle, busy starts, missing presence,
        // bit pair 1,1, setups and the last-device case.
        send_word(t_in_word'{OP_BITPAIR, 1'b1, 1'b1, 1'b0, 8'h00}, r);
        send_word(t_in_word'{OP_RST_OUT, 1'b0, 1'b0, 1'b1, 8'h00}, r);
        send_word(t_in_word'{OP_UNUSED,  1'b1, 1'b1, 1'b1, 8'hFF}, r);
        send_word(t_in_word'{OP_FIRST,   1'b0, 1'b0, 1'b0, 8'h00}, r);
        send_word(t_in_word'{OP_FIRST,   1'b1, 1'b1, 1'b1, 8'hFF}, r);
        send_word(t_in_word'{OP_RST_OUT, 1'b0, 1'b0, 1'b1, 8'h00}, r);
        send_word(t_in_word'{OP_NEXT,    1'b0, 1'b0, 1'b0, 8'h00}, r);
        send_word(t_in_word'{OP_RST_OUT, 1'b1, 1'b1, 1'b0, 8'hFF}, r);
        send_word(t_in_word'{OP_TARGET,  1'b1, 1'b1, 1'b1, 8'hFF}, r);
        send_word(t_in_word'{OP_BITPAIR, 1'b1, 1'b1, 1'b0, 8'h00}, r);
        send_word(t_in_word'{OP_TARGET,  1'b0, 1'b0, 1'b0, 8'h00}, r);
        send_word(t_in_word'{OP_SKIP,    1'b0, 1'b0, 1'b0, 8'h00}, r);
        send_word(t_in_word'{OP_NEXT,    1'b0, 1'b0, 1'b0, 8'h00}, r);
        send_word(t_in_word'{OP_TARGET,  1'b0, 1'b0, 1'b0, 8'hFF}, r);
        send_word(t_in_word'{OP_VERIFY,  1'b0, 1'b0, 1'b0, 8'h00}, r);
        send_word(t_in_word'{OP_RST_OUT, 1'b0, 1'b0, 1'b1, 8'h00}, r);

        // A complete search over devices whose family byte is zero.
        wait_for_results();
        write_command(8'hFF);
        new_bus(1'b1);
        send_word(t_in_word'{OP_FIRST, 1'b0, 1'b0, 1'b0, 8'h00}, r);
        advance_search();

        // First, verify and next over a normal bus.
        wait_for_results();
        write_command(8'h00);
        new_bus(1'b0);
        send_word(t_in_word'{OP_FIRST, 1'b0, 1'b0, 1'b0, 8'h00}, r);
        advance_search();
        send_word(t_in_word'{OP_VERIFY, 1'b0, 1'b0, 1'b0, 8'h00}, r);
        advance_search();
        send_word(t_in_word'{OP_NEXT, 1'b0, 1'b0, 1'b0, 8'h00}, r);
        advance_search();

        next_cfg_at = items_sent + $urandom_range(250, 450);
        while (items_sent < N_ITEMS) begin
            // A stray start may have opened a search; finish it first.
            advance_search();
            if (items_sent >= next_cfg_at) begin
                wait_for_results();
                case ($urandom_range(0, 4))
                    0: write_command(8'h00);
                    1: write_command(8'hFF);
                    2: write_command(8'hEC);
                    3: write_command(SEARCH_CMD_RESET);
                    default: write_command(8'($urandom));
                endcase
                next_cfg_at = items_sent + $urandom_range(250, 450);
            end
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                repeat ($urandom_range(1, 4))
                    send_word(random_word(), r);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    new_bus($urandom_range(0, 19) == 0);
                w = random_word();
                if (sel < 48) begin
                    w.opcode = OP_FIRST;
                end else if (sel < 74) begin
                    w.opcode = OP_NEXT;
                end else if (sel < 84) begin
                    w.opcode = OP_VERIFY;
                end else begin
                    if (sel < 92) begin
                        w.opcode = OP_TARGET;
                        if (bus_dev.size() != 0 && $urandom_range(0, 1))
                            w.family_byte = bus_dev[$urandom_range(0, bus_dev.size() - 1)][7:0];
                    end else begin
                        w.opcode = OP_SKIP;
                    end
                    send_word(w, r);
                    w = random_word();
                    w.opcode = OP_NEXT;
                end
                send_word(w, r);
                advance_search();
            end
        end

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.expected_results.size() == 0) begin
            $display("one_wire_rom_search_engine_tb passed");
        end else begin
            $display("one_wire_rom_search_engine_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> one_wire_rom_search_engine.f
+incdir+src
src/owse_pkg.sv
src/owse_core.sv
src/one_wire_rom_search_engine.sv
verif/one_wire_rom_search_engine_tb.sv
